// ===== design/wha_pkg.sv =====
// Shared constants, types and the saturating add function of the weighted histogram accumulator.
package wha_pkg;

  localparam int BINS           = 4096;
  localparam int COUNT_BITS     = 48;
  localparam int BIN_BITS       = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CMD_BITS       = 2;
  localparam int BIN_FIELD_BITS = 16;
  localparam int WEIGHT_BITS    = 16;
  localparam int OUT_COUNT_BITS = 48;
  localparam int OUT_MAX_BITS   = 12;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e_t;

  typedef enum logic [1:0] {
    OP_READ,
    OP_ADD,
    OP_DROP,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [BIN_BITS-1:0]    idx;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [WEIGHT_BITS-1:0] w);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, a} + (COUNT_BITS + 1)'(w);
    if (sum[COUNT_BITS]) begin
      return '1;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

endpackage

// ===== design/wha_if.sv =====
// Request and response channel interfaces of the weighted histogram accumulator.
interface wha_req_if;
  logic                                valid;
  logic                                ready;
  logic [wha_pkg::CMD_BITS-1:0]        cmd;
  logic [wha_pkg::BIN_FIELD_BITS-1:0]  bin;
  logic [wha_pkg::WEIGHT_BITS-1:0]     weight;

  modport source (output valid, output cmd, output bin, output weight, input ready);
  modport sink   (input valid, input cmd, input bin, input weight, output ready);
endinterface

interface wha_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [wha_pkg::OUT_COUNT_BITS-1:0]  bin_count;
  logic [wha_pkg::OUT_COUNT_BITS-1:0]  total_count;
  logic [wha_pkg::OUT_MAX_BITS-1:0]    max_bin;
  logic                                dropped;

  modport source (output valid, output bin_count, output total_count, output max_bin,
                  output dropped, input ready);
  modport sink   (input valid, input bin_count, input total_count, input max_bin,
                  input dropped, output ready);
endinterface

// ===== design/wha_front.sv =====
// Front end: accepts request items and classifies them into queue entries.
module wha_front (
  wha_req_if.sink            req,
  input  logic               q_full,
  input  logic               init_busy,
  output wha_pkg::q_push_t   push
);

  logic in_range;
  logic accept;

  assign in_range  = 32'(req.bin) < 32'(wha_pkg::BINS);
  assign req.ready = !q_full && !init_busy;
  assign accept    = req.valid && req.ready;

  always_comb begin
    push.valid        = accept;
    push.entry.idx    = wha_pkg::BIN_BITS'(req.bin);
    push.entry.weight = req.weight;
    case (req.cmd)
      wha_pkg::CMD_CLEAR: begin
        push.entry.op = wha_pkg::OP_CLEAR;
      end
      wha_pkg::CMD_ADD: begin
        if (!in_range) begin
          push.entry.op = wha_pkg::OP_DROP;
        end else if (req.weight != '0) begin
          push.entry.op = wha_pkg::OP_ADD;
        end else begin
          push.entry.op = wha_pkg::OP_READ;
        end
      end
      default: begin
        push.entry.op = in_range ? wha_pkg::OP_READ : wha_pkg::OP_DROP;
      end
    endcase
  end

endmodule

// ===== design/wha_queue.sv =====
// Short queue of classified items between the front and back ends.
module wha_queue (
  input  logic               clk,
  input  logic               rst,
  input  wha_pkg::q_push_t   push,
  input  logic               pop,
  output logic               full,
  output wha_pkg::q_head_t   head
);

  wha_pkg::entry_t                  slots [wha_pkg::QUEUE_DEPTH];
  logic [wha_pkg::QPTR_BITS-1:0]    wr_ptr;
  logic [wha_pkg::QPTR_BITS-1:0]    rd_ptr;
  logic [wha_pkg::QCNT_BITS-1:0]    count;
  logic                             do_push;
  logic                             do_pop;

  assign full       = count == wha_pkg::QCNT_BITS'(wha_pkg::QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == wha_pkg::QPTR_BITS'(wha_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == wha_pkg::QPTR_BITS'(wha_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/wha_back.sv =====
// Back end: bin memory, read-modify-write, totals, clear sweep and result register.
module wha_back (
  input  logic               clk,
  input  logic               rst,
  input  wha_pkg::q_head_t   head,
  output logic               pop,
  output logic               init_busy,
  wha_rsp_if.source          rsp
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_CALC,
    S_CLEAR
  } state_t;

  state_t                             state;
  logic [wha_pkg::COUNT_BITS-1:0]     mem [wha_pkg::BINS];
  logic [wha_pkg::COUNT_BITS-1:0]     mem_q;
  logic                               mem_we;
  logic [wha_pkg::BIN_BITS-1:0]       mem_waddr;
  logic [wha_pkg::COUNT_BITS-1:0]     mem_wdata;
  logic [wha_pkg::BIN_BITS-1:0]       sweep_addr;
  logic                               sweep_last;
  wha_pkg::entry_t                    cur;
  logic [wha_pkg::COUNT_BITS-1:0]     total;
  logic [wha_pkg::BIN_BITS-1:0]       highest;
  logic [wha_pkg::COUNT_BITS-1:0]     count_next;
  logic [wha_pkg::COUNT_BITS-1:0]     total_next;
  logic [wha_pkg::BIN_BITS-1:0]       highest_next;
  logic                               rsp_load;
  logic                               rsp_valid;
  logic [wha_pkg::OUT_COUNT_BITS-1:0] rsp_bin_count;
  logic [wha_pkg::OUT_COUNT_BITS-1:0] rsp_total;
  logic [wha_pkg::OUT_MAX_BITS-1:0]   rsp_max;
  logic                               rsp_dropped;

  assign pop        = (state == S_IDLE) && head.valid && (!rsp_valid || rsp.ready);
  assign init_busy  = state == S_INIT;
  assign sweep_last = sweep_addr == wha_pkg::BIN_BITS'(wha_pkg::BINS - 1);

  // result register is loaded this cycle
  assign rsp_load = (state == S_CALC) ||
                    (pop && (head.entry.op == wha_pkg::OP_DROP ||
                             head.entry.op == wha_pkg::OP_CLEAR));

  assign count_next   = (cur.op == wha_pkg::OP_ADD) ? wha_pkg::sat_add(mem_q, cur.weight) : mem_q;
  assign total_next   = (cur.op == wha_pkg::OP_ADD) ? wha_pkg::sat_add(total, cur.weight) : total;
  assign highest_next = (cur.op == wha_pkg::OP_ADD && cur.idx > highest) ? cur.idx : highest;

  assign mem_we    = (state == S_CALC && cur.op == wha_pkg::OP_ADD) ||
                     state == S_CLEAR || state == S_INIT;
  assign mem_waddr = (state == S_CALC) ? cur.idx : sweep_addr;
  assign mem_wdata = (state == S_CALC) ? count_next : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[head.entry.idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep_addr <= '0;
      total      <= '0;
      highest    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp.ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT, S_CLEAR: begin
          sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur <= head.entry;
            case (head.entry.op)
              wha_pkg::OP_ADD, wha_pkg::OP_READ: begin
                state <= S_CALC;
              end
              wha_pkg::OP_DROP: begin
                rsp_valid     <= 1'b1;
                rsp_bin_count <= '0;
                rsp_total     <= wha_pkg::OUT_COUNT_BITS'(total);
                rsp_max       <= wha_pkg::OUT_MAX_BITS'(highest);
                rsp_dropped   <= 1'b1;
              end
              default: begin
                total         <= '0;
                highest       <= '0;
                sweep_addr    <= '0;
                rsp_valid     <= 1'b1;
                rsp_bin_count <= '0;
                rsp_total     <= '0;
                rsp_max       <= '0;
                rsp_dropped   <= 1'b0;
                state         <= S_CLEAR;
              end
            endcase
          end
        end
        S_CALC: begin
          total         <= total_next;
          highest       <= highest_next;
          rsp_valid     <= 1'b1;
          rsp_bin_count <= wha_pkg::OUT_COUNT_BITS'(count_next);
          rsp_total     <= wha_pkg::OUT_COUNT_BITS'(total_next);
          rsp_max       <= wha_pkg::OUT_MAX_BITS'(highest_next);
          rsp_dropped   <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.bin_count   = rsp_bin_count;
  assign rsp.total_count = rsp_total;
  assign rsp.max_bin     = rsp_max;
  assign rsp.dropped     = rsp_dropped;

`ifndef ASSERT_OFF
  a_calc_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |-> !rsp_valid)
    else $error("result register busy while a bin update completes");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && $past(state) == S_IDLE) |->
      (rsp_valid && rsp_total == '0 && rsp_max == '0 && total == '0 && highest == '0))
    else $error("clear did not zero totals and result");

  a_highest_only_clears: assert property (@(posedge clk) disable iff (rst)
    (highest < $past(highest)) |-> (state == S_CLEAR))
    else $error("highest bin fell outside a clear");
`endif

endmodule

// ===== design/weighted_histogram_accumulator_top.sv =====
// Top level of the weighted histogram accumulator.
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+-------------
//  req     | in  | cmd[1:0], bin[15:0], weight[15:0]         | valid/ready
//  rsp     | out | bin_count[47:0], total_count[47:0],       | valid/ready
//          |     | max_bin[11:0], dropped                   |
//
//  Add and read items in range pass through the back end as a memory read, then an
//  update and write back (the bin memory has one read and one write port).
//  Out-of-range items are answered from the idle state. A clear item runs the sweep
//  that zeroes the bin memory. After reset a clearing pass runs; req.ready stays low
//  until it ends. A two-entry queue keeps req accepting while a result waits on rsp.
module weighted_histogram_accumulator_top (
  input  logic       clk,
  input  logic       rst,
  wha_req_if.sink    req,
  wha_rsp_if.source  rsp
);

  wha_pkg::q_push_t  push;
  wha_pkg::q_head_t  head;
  logic              q_full;
  logic              pop;
  logic              init_busy;

  wha_front u_front (
    .req       (req),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push)
  );

  wha_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  wha_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

endmodule
